>>> src/http_chunked_body_decoder_defines.svh
// Assertion macros used by the chunked body decoder core.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define HCBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Width of the chunk size and byte counter.
  localparam int SIZE_BITS = 32;

  // Decoder phases.
  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // End status codes.
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  // Line delimiters and the trailer length after each chunk.
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [SIZE_BITS-1:0] TRAIL_LEN = SIZE_BITS'(2);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [1:0] end_status;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit.
  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.is_hex = 1'b0;
    h.val    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.is_hex = 1'b1;
      h.val    = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.is_hex = 1'b1;
      h.val    = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.is_hex = 1'b1;
      h.val    = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> src/hcbd_if.sv
`default_nettype none

// Raw body byte channel.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// Decoded result channel.
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [1:0] end_status;

  modport source (output valid, output data_byte, output data_valid, output end_status,
                  input ready);
  modport sink (input valid, input data_byte, input data_valid, input end_status,
                output ready);
endinterface

`default_nettype wire

>>> src/hcbd_in_reg.sv
`default_nettype none

module hcbd_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  hcbd_in_if.sink             in_chan,
  input  wire logic           adv,
  output hcbd_pkg::item_t     item,
  output logic                item_vld
);

  logic            vld_r;
  logic            vld_nxt;
  hcbd_pkg::item_t item_r;
  logic            take;

  // The register frees up when its item moves on in the same cycle.
  assign in_chan.ready = !vld_r || adv;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register, loaded on each accepted item.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.in_byte <= in_chan.in_byte;
      item_r.is_last <= in_chan.is_last;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;

endmodule

`default_nettype wire

>>> src/hcbd_core.sv
`default_nettype none

`include "http_chunked_body_decoder_defines.svh"

module hcbd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire hcbd_pkg::item_t item,
  output hcbd_pkg::result_t    res
);

  localparam int SB = hcbd_pkg::SIZE_BITS;

  logic [1:0]    phase_r, phase_nxt;
  logic          digits_open_r, digits_open_nxt;
  logic          cr_pending_r, cr_pending_nxt;
  logic [SB-1:0] count_r, count_nxt;

  hcbd_pkg::hex_t hd;
  logic [SB-1:0]  count_dec;

  assign hd        = hcbd_pkg::hex_digit(item.in_byte);
  assign count_dec = count_r - SB'(1);

  // One byte of the decoder: phase update, payload pass-through and status.
  always_comb begin
    phase_nxt       = phase_r;
    digits_open_nxt = digits_open_r;
    cr_pending_nxt  = cr_pending_r;
    count_nxt       = count_r;
    res.data_byte   = 8'd0;
    res.data_valid  = 1'b0;
    res.end_status  = hcbd_pkg::ST_RUN;

    unique case (phase_r)
      hcbd_pkg::PH_SIZE: begin
        // Gather hex digits, saturating when the size would overflow.
        if (digits_open_r && hd.is_hex) begin
          if (count_r[SB-1 -: 4] != 4'd0) begin
            count_nxt = '1;
          end else begin
            count_nxt = {count_r[SB-5:0], hd.val};
          end
        end else begin
          digits_open_nxt = 1'b0;
        end
        // The line ends on CR immediately followed by LF.
        if (cr_pending_r && item.in_byte == hcbd_pkg::BYTE_LF) begin
          digits_open_nxt = 1'b1;
          cr_pending_nxt  = 1'b0;
          phase_nxt       = (count_nxt == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
        end else begin
          cr_pending_nxt = (item.in_byte == hcbd_pkg::BYTE_CR);
        end
      end
      hcbd_pkg::PH_DATA: begin
        res.data_byte  = item.in_byte;
        res.data_valid = 1'b1;
        count_nxt      = count_dec;
        if (count_dec == '0) begin
          phase_nxt = hcbd_pkg::PH_SKIP;
          count_nxt = hcbd_pkg::TRAIL_LEN;
        end
      end
      hcbd_pkg::PH_SKIP: begin
        count_nxt = count_dec;
        if (count_dec == '0) begin
          phase_nxt       = hcbd_pkg::PH_SIZE;
          digits_open_nxt = 1'b1;
          cr_pending_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (phase_nxt == hcbd_pkg::PH_DONE) begin
      res.end_status = hcbd_pkg::ST_DONE;
    end

    // The last byte of a body reports the outcome and rearms for the next body.
    if (item.is_last) begin
      if (phase_nxt != hcbd_pkg::PH_DONE) begin
        res.end_status = hcbd_pkg::ST_EARLY;
      end
      phase_nxt       = hcbd_pkg::PH_SIZE;
      digits_open_nxt = 1'b1;
      cr_pending_nxt  = 1'b0;
      count_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hcbd_pkg::PH_SIZE;
      digits_open_r <= 1'b1;
      cr_pending_r  <= 1'b0;
      count_r       <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      digits_open_r <= digits_open_nxt;
      cr_pending_r  <= cr_pending_nxt;
      count_r       <= count_nxt;
    end
  end

  // Payload only leaves during the payload phase.
  `HCBD_ASSERT_SAME(a_payload_phase, step && res.data_valid,
                    phase_r == hcbd_pkg::PH_DATA, "payload byte outside payload phase")
  // A payload phase always has bytes left to pass.
  `HCBD_ASSERT_SAME(a_data_count, phase_r == hcbd_pkg::PH_DATA, count_r != '0,
                    "payload phase with empty count")
  // The trailer skip counts down from two.
  `HCBD_ASSERT_SAME(a_skip_count, phase_r == hcbd_pkg::PH_SKIP,
                    count_r == SB'(1) || count_r == SB'(2), "bad trailer count")
  // The last byte of a body leaves the decoder ready for a fresh size line.
  `HCBD_ASSERT_NEXT(a_rearm, step && item.is_last,
                    phase_r == hcbd_pkg::PH_SIZE && digits_open_r && !cr_pending_r
                    && count_r == '0, "decoder not rearmed after last byte")

endmodule

`default_nettype wire

>>> src/hcbd_out_reg.sv
`default_nettype none

module hcbd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire hcbd_pkg::result_t res,
  output logic                   can_take,
  hcbd_out_if.source             out_chan
);

  logic              vld_r;
  logic              vld_nxt;
  hcbd_pkg::result_t res_r;

  // Room when empty or when the current item leaves this cycle.
  assign can_take = !vld_r || out_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = vld_r;
  assign out_chan.data_byte  = res_r.data_byte;
  assign out_chan.data_valid = res_r.data_valid;
  assign out_chan.end_status = res_r.end_status;

endmodule

`default_nettype wire

>>> src/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder. Takes one body byte per item with a flag on the
// final byte and returns exactly one result item per byte: the payload byte with
// data_valid set, or a skipped framing byte, plus an end status (running, body
// complete, or body ended before its terminating zero-size line). A new byte is
// accepted every clock while the result side keeps taking items; each byte passes
// through the input register and then the result register. The rate is set by the
// update of the phase and size counter, which every byte reads and writes. Chunk
// sizes saturate at 2^32-1.
`default_nettype none

module http_chunked_body_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hcbd_in_if.sink     in_chan,
  hcbd_out_if.source  out_chan
);

  hcbd_pkg::item_t   item;
  hcbd_pkg::result_t res;
  logic              item_vld;
  logic              can_take;
  logic              adv;

  // An item moves through the decoder when the result register has room.
  assign adv = item_vld && can_take;

  hcbd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .adv      (adv),
    .item     (item),
    .item_vld (item_vld)
  );

  hcbd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item),
    .res   (res)
  );

  hcbd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .res      (res),
    .can_take (can_take),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_http_chunked_body_decoder.sv
module tb_http_chunked_body_decoder;

  // Keeps its own copy of the decoder state and checks each result item.
  class chunk_decode_checker;
    hcbd_pkg::result_t               due_q[$];
    logic [1:0]                      phase;
    bit                              digits_open;
    bit                              cr_seen;
    logic [hcbd_pkg::SIZE_BITS-1:0]  remaining;
    int unsigned                     bad_count;
    int unsigned                     result_count;
    int unsigned                     payload_count;
    int unsigned                     complete_count;
    int unsigned                     early_count;

    function new();
      restart();
    endfunction

    function void restart();
      phase       = hcbd_pkg::PH_SIZE;
      digits_open = 1'b1;
      cr_seen     = 1'b0;
      remaining   = '0;
    endfunction

    // Bit 4 set when the byte is a hex digit, low nibble is its value.
    function logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
    endfunction

    // Predict the result of one accepted body byte.
    function void note_byte(hcbd_pkg::item_t it);
      hcbd_pkg::result_t r;
      logic [4:0]        hv;
      r = '0;
      r.end_status = hcbd_pkg::ST_RUN;
      case (phase)
        hcbd_pkg::PH_SIZE: begin
          hv = hex_nibble(it.in_byte);
          if (digits_open && hv[4]) begin
            // The size saturates once another digit would not fit.
            if (remaining > ({hcbd_pkg::SIZE_BITS{1'b1}} >> 4)) remaining = '1;
            else remaining = (remaining << 4) | hcbd_pkg::SIZE_BITS'(hv[3:0]);
          end else begin
            digits_open = 1'b0;
          end
          if (cr_seen && it.in_byte == hcbd_pkg::BYTE_LF) begin
            digits_open = 1'b1;
            cr_seen     = 1'b0;
            phase       = (remaining == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
          end else begin
            cr_seen = (it.in_byte == hcbd_pkg::BYTE_CR);
          end
        end
        hcbd_pkg::PH_DATA: begin
          r.data_byte  = it.in_byte;
          r.data_valid = 1'b1;
          remaining    = remaining - 1'b1;
          if (remaining == '0) begin
            phase     = hcbd_pkg::PH_SKIP;
            remaining = hcbd_pkg::TRAIL_LEN;
          end
        end
        hcbd_pkg::PH_SKIP: begin
          remaining = remaining - 1'b1;
          if (remaining == '0) restart();
        end
        default: ;
      endcase
      if (phase == hcbd_pkg::PH_DONE) r.end_status = hcbd_pkg::ST_DONE;
      if (it.is_last) begin
        if (phase != hcbd_pkg::PH_DONE) begin
          r.end_status = hcbd_pkg::ST_EARLY;
          early_count++;
        end else begin
          complete_count++;
        end
        restart();
      end
      if (r.data_valid) payload_count++;
      due_q.insert(due_q.size(), r);
    endfunction

    // Compare one accepted result item with the oldest prediction.
    function void check_result(hcbd_pkg::result_t got);
      hcbd_pkg::result_t exp_r;
      result_count++;
      if (due_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result item %0d: data_byte %h data_valid %b end_status %0d",
                   result_count, got.data_byte, got.data_valid, got.end_status);
        return;
      end
      exp_r = due_q.pop_front();
      if (got.data_byte != exp_r.data_byte || got.data_valid != exp_r.data_valid ||
          got.end_status != exp_r.end_status) begin
        bad_count++;
        if (bad_count <= 10)
          $display({"result item %0d differs: data_byte exp %h got %h, data_valid exp %b ",
                    "got %b, end_status exp %0d got %0d"}, result_count,
                   exp_r.data_byte, got.data_byte, exp_r.data_valid, got.data_valid,
                   exp_r.end_status, got.end_status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hcbd_in_if  in_chan ();
  hcbd_out_if out_chan ();

  http_chunked_body_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  chunk_decode_checker checker_h = new();
  hcbd_pkg::item_t     body_bytes[$];
  bit                  calm;
  int unsigned         stall_left;
  int unsigned         bytes_sent;
  int unsigned         bodies_sent;

  // Clock with a period of 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      stall_left     <= pick_gap();
    end
  end

  // Check every result item taken by the result side.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      checker_h.check_result('{data_byte: out_chan.data_byte,
                               data_valid: out_chan.data_valid,
                               end_status: out_chan.end_status});
  end

  // Offer one byte, after an optional gap, and hold it until it is taken.
  task automatic push_byte(input hcbd_pkg::item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= it.in_byte;
    in_chan.is_last <= it.is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    checker_h.note_byte(it);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    hcbd_pkg::item_t it;
    it.in_byte = b;
    it.is_last = 1'b0;
    body_bytes.insert(body_bytes.size(), it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(hcbd_pkg::BYTE_CR);
    add_byte(hcbd_pkg::BYTE_LF);
  endtask

  // Size line with random case, leading zeros and sometimes an extension.
  task automatic add_size_line(input int unsigned n);
    string s;
    s = $sformatf("%0h", n);
    if ($urandom_range(0, 1)) s = s.toupper();
    if ($urandom_range(0, 3) == 0) s = {"00", s};
    add_text(s);
    if ($urandom_range(0, 4) == 0) begin
      add_text(";");
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(8'h67, 8'h7a)));
      // A lone CR or LF inside the extension must not end the line.
      case ($urandom_range(0, 3))
        0: begin add_byte(hcbd_pkg::BYTE_CR); add_text("x"); end
        1: add_byte(hcbd_pkg::BYTE_LF);
        default: ;
      endcase
    end
    add_crlf();
  endtask

  // Flag the final byte and send the whole body.
  task automatic send_body();
    body_bytes[$].is_last = 1'b1;
    foreach (body_bytes[i]) push_byte(body_bytes[i]);
    body_bytes.delete();
    bodies_sent++;
  endtask

  // Stop offering bytes and wait until every predicted result has come.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (checker_h.due_q.size() != 0) @(posedge clk);
  endtask

  // Random body: mostly well formed, some cut short, some pure noise.
  task automatic build_random_body();
    int unsigned kind;
    int unsigned size;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 11) begin
      // Large size, most often too large for the counter.
      add_text("1");
      repeat ($urandom_range(7, 12)) add_text($urandom_range(0, 1) ? "f" : "A");
      add_crlf();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      cut = $urandom_range(0, 99);
      size = (cut < 70) ? $urandom_range(1, 8) :
             (cut < 95) ? $urandom_range(9, 48) : $urandom_range(49, 300);
      add_size_line(size);
      repeat (size) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) add_crlf();
      else repeat (2) add_byte(8'($urandom_range(0, 255)));
    end
    // Terminating line, sometimes without any digits.
    if ($urandom_range(0, 19) == 0) add_crlf();
    else add_size_line(0);
    case ($urandom_range(0, 2))
      0: add_crlf();
      1: begin add_text("X-Tail: v"); add_crlf(); add_crlf(); end
      default: ;
    endcase
    if (kind >= 85) begin
      cut = $urandom_range(0, body_bytes.size() - 1);
      body_bytes = body_bytes[0:cut];
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    calm             = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= 8'h00;
    in_chan.is_last <= 1'b0;
    bytes_sent       = 0;
    bodies_sent      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // One short chunk, a byte after the terminator, and a zero last byte.
    add_text("1");
    add_crlf();
    add_byte(8'hFF);
    add_text("xy0");
    add_crlf();
    add_byte(8'h00);
    send_body();
    // Stray LF and CR, then a size line with no digits.
    add_byte(hcbd_pkg::BYTE_LF);
    add_byte(hcbd_pkg::BYTE_CR);
    add_crlf();
    send_body();
    // Saturating size, body cut before its end.
    add_text("fFfFfFfFf");
    add_byte(hcbd_pkg::BYTE_CR);
    send_body();

    // Hold off until every predicted result has come back.
    wait_drained();

    while (bytes_sent < 1500) begin
      calm = ($urandom_range(0, 4) == 0);
      build_random_body();
      send_body();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes in %0d bodies: %0d payload bytes, %0d complete, %0d early.",
             bytes_sent, bodies_sent, checker_h.payload_count, checker_h.complete_count,
             checker_h.early_count);
    $display("%0d result items checked, %0d mismatches.", checker_h.result_count,
             checker_h.bad_count);
    if (checker_h.bad_count == 0 && checker_h.due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Timed out with %0d results outstanding.", checker_h.due_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
